// ----- design/sva_pkg.sv -----
package sva_pkg;

    // Default voice count and fixed field widths
    localparam int VOICES_DEF  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int PITCH_W     = 7;
    localparam int VOICE_W     = 3;
    localparam int CHAN_W      = 4;
    localparam int STEAL_W     = 3;
    localparam int CMP_W       = 5;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 16;

    // Input action codes (s_axis_tuser)
    localparam logic [1:0] ACT_NOTE_OFF = 2'd0;
    localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    // Output command codes (m_axis_tuser)
    localparam logic CMD_RELEASE = 1'b0;
    localparam logic CMD_RETRIG  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_CLEAR
    } state_t;

endpackage

// ----- design/synth_voice_allocator.sv -----
// Voice allocator: turns note events into voice commands for VOICES synthesizer
// voices. Input words carry action in tuser (0 note off, 1 note on, 2 clear all,
// 3 ignored) and channel, pitch and steal voice in tdata. Each output word is
// one command (tuser: 0 release, 1 retrigger) with voice and tone in tdata and
// tlast on the final word of an event. In poly mode (channel_mode = 0) one
// compare unit walks the voice store one entry per cycle, looking for a busy
// voice that holds the pitch and for the lowest free voice; a note-on for a
// held pitch is dropped, otherwise it takes the lowest free voice or the steal
// voice (saturated to VOICES-1) when all are busy. A note-off releases the
// busy voice holding its pitch, if any. In channel mode the MIDI channel is the
// voice; channels of VOICES or more are dropped. A clear frees every voice at
// once and emits min(VOICES, 8) releases, voice 0 upward. Timing: the block
// takes one event at a time: a poly event runs the voice scan and then the
// decide state, a channel-mode event scans its own voice only, a clear keeps
// the input closed while its releases go out, and a reserved or dropped event
// leaves it open. An output stall holds the decide and clear states. A finished
// word waits in the output register while the next event is accepted. The store
// is ready right after reset. Write channel_mode only while no event is in flight.
module synth_voice_allocator #(
    parameter int VOICES = sva_pkg::VOICES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: channel_mode
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    // event input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [3:0] midi_channel, [10:4] pitch, [13:11] steal_channel, [15:14] zero
    input  logic [sva_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                     s_axis_tuser,
    // command output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [2:0] voice, [9:3] tone, [15:10] zero
    output logic [sva_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] command
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import sva_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CLR_N = (VOICES < MAX_RESULTS) ? VOICES : MAX_RESULTS;

    // Unpacked input fields
    logic [CHAN_W-1:0]  in_chan;
    logic [PITCH_W-1:0] in_pitch;
    logic [STEAL_W-1:0] in_steal;
    logic               in_accept;
    logic               chan_ok;
    logic [IDX_W-1:0]   steal_sat;

    assign in_chan   = s_axis_tdata[CHAN_W-1:0];
    assign in_pitch  = s_axis_tdata[CHAN_W+PITCH_W-1:CHAN_W];
    assign in_steal  = s_axis_tdata[CHAN_W+PITCH_W+STEAL_W-1:CHAN_W+PITCH_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign chan_ok   = {1'b0, in_chan} < CMP_W'(VOICES);
    assign steal_sat = ({2'b00, in_steal} >= CMP_W'(VOICES)) ? IDX_W'(VOICES - 1)
                                                             : IDX_W'(in_steal);

    // Control and event registers
    state_t             state_reg, state_next;
    logic               mode_reg;
    logic [1:0]         act_reg, act_next;
    logic [IDX_W-1:0]   chan_reg, chan_next;
    logic [PITCH_W-1:0] pitch_reg, pitch_next;
    logic [IDX_W-1:0]   steal_reg, steal_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               held_found_reg, held_found_next;
    logic [IDX_W-1:0]   held_idx_reg, held_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [VOICE_W-1:0] clr_reg, clr_next;

    // Voice store
    logic [VOICES-1:0]  busy_reg, busy_next;
    logic [PITCH_W-1:0] vpitch_reg [VOICES];
    logic               vp_we;
    logic [IDX_W-1:0]   vp_waddr;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_cmd_reg, out_cmd_next;
    logic [VOICE_W-1:0] out_voice_reg, out_voice_next;
    logic [PITCH_W-1:0] out_tone_reg, out_tone_next;
    logic               out_last_reg, out_last_next;
    logic               can_load;

    // Shared compare unit on the entry under the scan index
    logic               hit;
    logic               free_here;
    logic               scan_done;

    assign hit       = busy_reg[idx_reg] && (vpitch_reg[idx_reg] == pitch_reg);
    assign free_here = !busy_reg[idx_reg];
    assign scan_done = mode_reg || (idx_reg == IDX_W'(VOICES - 1));
    assign can_load  = !out_valid_reg || m_axis_tready;

    // Take a new event only while idle
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Decision at the end of a scan
    logic               dec_emit;
    logic               dec_cmd;
    logic [IDX_W-1:0]   dec_voice;
    logic               clr_last;

    always_comb
    begin
        dec_cmd   = CMD_RELEASE;
        dec_emit  = 1'b0;
        dec_voice = held_idx_reg;
        if (act_reg == ACT_NOTE_ON)
        begin
            dec_cmd = CMD_RETRIG;
            if (mode_reg)
            begin
                dec_emit  = 1'b1;
                dec_voice = chan_reg;
            end
            else
            begin
                dec_emit  = !held_found_reg;
                dec_voice = free_found_reg ? free_idx_reg : steal_reg;
            end
        end
        else
        begin
            dec_emit = held_found_reg;
        end
    end

    assign clr_last = (clr_reg == VOICE_W'(CLR_N - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_axis_tuser)
                        ACT_CLEAR:    state_next = ST_CLEAR;
                        ACT_RESERVED: state_next = ST_IDLE;
                        default:
                        begin
                            if (!mode_reg || chan_ok)
                                state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!dec_emit || can_load)
                    state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (can_load && clr_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output next values
    always_comb
    begin
        act_next        = act_reg;
        chan_next       = chan_reg;
        pitch_next      = pitch_reg;
        steal_next      = steal_reg;
        idx_next        = idx_reg;
        held_found_next = held_found_reg;
        held_idx_next   = held_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        clr_next        = clr_reg;
        busy_next       = busy_reg;
        vp_we           = 1'b0;
        vp_waddr        = dec_voice;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_cmd_next    = out_cmd_reg;
        out_voice_next  = out_voice_reg;
        out_tone_next   = out_tone_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    // latch the event and arm the scan
                    act_next        = s_axis_tuser;
                    chan_next       = IDX_W'(in_chan);
                    pitch_next      = in_pitch;
                    steal_next      = steal_sat;
                    idx_next        = mode_reg ? IDX_W'(in_chan) : '0;
                    held_found_next = 1'b0;
                    free_found_next = 1'b0;
                    clr_next        = '0;
                    if (s_axis_tuser == ACT_CLEAR)
                        busy_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (hit && !held_found_reg)
                begin
                    held_found_next = 1'b1;
                    held_idx_next   = idx_reg;
                end
                if (free_here && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (!scan_done)
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_DECIDE:
            begin
                if (dec_emit && can_load)
                begin
                    out_valid_next = 1'b1;
                    out_cmd_next   = dec_cmd;
                    out_voice_next = VOICE_W'(dec_voice);
                    out_last_next  = 1'b1;
                    if (dec_cmd == CMD_RETRIG)
                    begin
                        out_tone_next       = pitch_reg;
                        busy_next[dec_voice] = 1'b1;
                        vp_we               = 1'b1;
                    end
                    else
                    begin
                        out_tone_next        = '0;
                        busy_next[dec_voice] = 1'b0;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_cmd_next   = CMD_RELEASE;
                    out_voice_next = clr_reg;
                    out_tone_next  = '0;
                    out_last_next  = clr_last;
                    clr_next       = clr_reg + VOICE_W'(1);
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= 1'b0;
            busy_reg       <= '0;
            out_valid_reg  <= 1'b0;
            held_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            idx_reg        <= '0;
            clr_reg        <= '0;
            act_reg        <= ACT_NOTE_OFF;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            held_found_reg <= held_found_next;
            free_found_reg <= free_found_next;
            idx_reg        <= idx_next;
            clr_reg        <= clr_next;
            act_reg        <= act_next;
            if (cfg_we)
                mode_reg <= cfg_wdata;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        chan_reg      <= chan_next;
        pitch_reg     <= pitch_next;
        steal_reg     <= steal_next;
        held_idx_reg  <= held_idx_next;
        free_idx_reg  <= free_idx_next;
        out_cmd_reg   <= out_cmd_next;
        out_voice_reg <= out_voice_next;
        out_tone_reg  <= out_tone_next;
        out_last_reg  <= out_last_next;
    end

    // Pitch store: one write port, read by the compare unit
    always_ff @(posedge clk)
    begin
        if (vp_we)
            vpitch_reg[vp_waddr] <= pitch_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_cmd_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - VOICE_W - PITCH_W)'(0), out_tone_reg, out_voice_reg};

endmodule

// ----- design/sva_checker.sv -----
module sva_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [1:0]                     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [sva_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser,
    input logic                           m_axis_tlast
);
    import sva_pkg::*;

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // A clear keeps the input closed while its releases go out
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_CLEAR) |=> !s_axis_tready)
        else $error("input open right after a clear");

    // A release carries a zero tone
    a_release_tone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == CMD_RELEASE) |->
            (m_axis_tdata[VOICE_W+PITCH_W-1:VOICE_W] == '0))
        else $error("release with nonzero tone");

    // A retrigger is always the only word of its event
    a_retrig_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == CMD_RETRIG) |-> m_axis_tlast)
        else $error("retrigger without tlast");

endmodule

bind synth_voice_allocator sva_checker u_sva_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
